// ===== hdl/ipv6ah_pkg.sv =====
// Package for the IPv6 AH mutable-field clear unit.
// Holds parse phase types, header type codes and the result word struct.
// No dependencies.
package ipv6ah_pkg;

    // Bytes beyond this offset pass unchanged and do not advance the parse.
    localparam int unsigned MAX_PACKET_BYTES = 2048;

    // Next-header codes that the parser follows.
    localparam logic [7:0] TYPE_HOP     = 8'd0;
    localparam logic [7:0] TYPE_ROUTING = 8'd43;
    localparam logic [7:0] TYPE_AUTH    = 8'd51;
    localparam logic [7:0] TYPE_DEST    = 8'd60;

    // Option type bit that marks option data as changing en route.
    localparam int unsigned MUTABLE_BIT_POS = 5;
    localparam logic [15:0] OPT_HEAD_BYTES  = 16'd2;

    // Fixed-header layout.
    localparam logic [15:0] FIXED_HDR_BYTES = 16'd40;
    localparam logic [15:0] FIXED_NH_OFFSET = 16'd6;

    // Offsets inside extension headers.
    localparam logic [15:0] REL_NEXT_HDR   = 16'd0;
    localparam logic [15:0] REL_HDR_LEN    = 16'd1;
    localparam logic [15:0] REL_SEG_LEFT   = 16'd3;
    localparam logic [15:0] REL_AUTH_DATA  = 16'd12;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_OPTS,
        PH_ROUTE,
        PH_AUTH,
        PH_DEST_AFTER_AUTH,
        PH_DONE,
        PH_ERROR
    } parse_phase_t;

    typedef enum logic [1:0] {
        OP_TYPE,
        OP_LEN,
        OP_DATA
    } option_phase_t;

    // One result word as produced by the parser.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_out;
        logic        status;
        logic [7:0]  next_header;
        logic [15:0] prev_header_offset;
    } result_t;

endpackage

// ===== hdl/ipv6_ah_mutable_field_clear_unit.sv =====
// Path: a word accepted into the input register moves on into the result register
// when the result register is free.
// Throughput: one word per cycle, set by the single parse step between the input
// register and the result register; while a result waits the input register takes
// one more word and then the input stalls until the result is taken.
// Reset: synchronous, active-low aresetn clears the handshake state and the parse
// state and sets zero_auth_data to 0.
// Top level of the IPv6 AH mutable-field clear unit; depends on ipv6ah_pkg, ipv6ah_parser.
module ipv6_ah_mutable_field_clear_unit
    import ipv6ah_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_zero_auth_data,
    // Input word channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_last_byte,
    // Result word channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_out,
    output logic        m_status,
    output logic [7:0]  m_next_header,
    output logic [15:0] m_prev_header_offset
);

    logic       zero_auth_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    step_result;
    logic       advance;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_auth_reg <= 1'b0;
        end else if (cfg_valid) begin
            zero_auth_reg <= cfg_zero_auth_data;
        end
    end

    // Handshake: the input word moves on whenever the result register is free.
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_packet_byte;
            in_last_reg <= s_last_byte;
        end
    end

    ipv6ah_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .packet_byte    (in_byte_reg),
        .last_byte      (in_last_reg),
        .zero_auth_data (zero_auth_reg),
        .result         (step_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_out_byte           = out_reg.out_byte;
    assign m_last_out           = out_reg.last_out;
    assign m_status             = out_reg.status;
    assign m_next_header        = out_reg.next_header;
    assign m_prev_header_offset = out_reg.prev_header_offset;

endmodule

// ===== hdl/ipv6ah_parser.sv =====
// Extension header walker: parse state registers and the per-byte step logic.
// Depends on ipv6ah_pkg.
module ipv6ah_parser
    import ipv6ah_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] packet_byte,
    input  logic       last_byte,
    input  logic       zero_auth_data,
    output result_t    result
);

    parse_phase_t  phase_reg, phase_next;
    option_phase_t opt_phase_reg, opt_phase_next;
    logic [15:0]   byte_count_reg, byte_count_next;
    logic [7:0]    next_type_reg, next_type_next;
    logic [15:0]   header_start_reg, header_start_next;
    logic [15:0]   header_end_reg, header_end_next;
    logic [15:0]   last_nh_offset_reg, last_nh_offset_next;
    logic [7:0]    option_left_reg, option_left_next;
    logic          option_zeroing_reg, option_zeroing_next;
    logic          error_seen_reg, error_seen_next;

    logic          active;
    logic [15:0]   rel;
    logic [16:0]   remaining;
    logic          rem_borrow;
    logic [16:0]   end_sum;
    logic [11:0]   opt_hdr_len;
    logic [10:0]   auth_hdr_len;
    logic [7:0]    out_byte;
    logic [7:0]    summary_nh;

    assign active       = byte_count_reg < 16'(MAX_PACKET_BYTES);
    assign opt_hdr_len  = {(9'(packet_byte) + 9'd1), 3'b000};
    assign auth_hdr_len = {(9'(packet_byte) + 9'd2), 2'b00};
    assign remaining    = {1'b0, header_end_reg} - {1'b0, byte_count_reg};
    assign rem_borrow   = remaining[16];

    // One parse step for the byte in the input register.
    always_comb begin
        phase_next          = phase_reg;
        opt_phase_next      = opt_phase_reg;
        byte_count_next     = byte_count_reg;
        next_type_next      = next_type_reg;
        header_start_next   = header_start_reg;
        header_end_next     = header_end_reg;
        last_nh_offset_next = last_nh_offset_reg;
        option_left_next    = option_left_reg;
        option_zeroing_next = option_zeroing_reg;
        error_seen_next     = error_seen_reg;
        out_byte            = packet_byte;
        rel                 = '0;
        end_sum             = '0;

        if (active) begin
            // Header boundary: pick the phase for the header that starts here.
            if (phase_reg <= PH_DEST_AFTER_AUTH && byte_count_reg == header_end_reg) begin
                case (phase_reg)
                    PH_AUTH: begin
                        if (next_type_reg == TYPE_DEST) begin
                            phase_next          = PH_DEST_AFTER_AUTH;
                            header_start_next   = byte_count_reg;
                            opt_phase_next      = OP_TYPE;
                            option_left_next    = '0;
                            option_zeroing_next = 1'b0;
                        end else begin
                            next_type_next = TYPE_AUTH;
                            phase_next     = PH_DONE;
                        end
                    end
                    PH_DEST_AFTER_AUTH: begin
                        next_type_next = TYPE_AUTH;
                        phase_next     = PH_DONE;
                    end
                    default: begin
                        if (next_type_reg == TYPE_HOP || next_type_reg == TYPE_DEST ||
                            next_type_reg == TYPE_ROUTING || next_type_reg == TYPE_AUTH) begin
                            header_start_next   = byte_count_reg;
                            opt_phase_next      = OP_TYPE;
                            option_left_next    = '0;
                            option_zeroing_next = 1'b0;
                            if (next_type_reg == TYPE_ROUTING) begin
                                phase_next          = PH_ROUTE;
                                last_nh_offset_next = byte_count_reg;
                            end else if (next_type_reg == TYPE_AUTH) begin
                                phase_next = PH_AUTH;
                            end else begin
                                phase_next          = PH_OPTS;
                                last_nh_offset_next = byte_count_reg;
                            end
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                endcase
            end

            rel = byte_count_reg - header_start_next;

            // Field handling within the current header.
            case (phase_next)
                PH_FIXED: begin
                    if (rel == FIXED_NH_OFFSET) begin
                        next_type_next = packet_byte;
                    end
                end
                PH_OPTS, PH_DEST_AFTER_AUTH: begin
                    if (rel == REL_NEXT_HDR) begin
                        if (phase_next == PH_OPTS) begin
                            next_type_next = packet_byte;
                        end
                    end else if (rel == REL_HDR_LEN) begin
                        end_sum         = {1'b0, header_start_next} + 17'(opt_hdr_len);
                        header_end_next = end_sum[16] ? 16'hFFFF : end_sum[15:0];
                    end else begin
                        // Option area: type, length, then data bytes.
                        case (opt_phase_next)
                            OP_TYPE: begin
                                if (packet_byte != 8'd0) begin
                                    if (!rem_borrow && remaining < 17'(OPT_HEAD_BYTES)) begin
                                        error_seen_next = 1'b1;
                                        phase_next      = PH_ERROR;
                                    end else begin
                                        option_zeroing_next = packet_byte[MUTABLE_BIT_POS];
                                        opt_phase_next      = OP_LEN;
                                    end
                                end
                            end
                            OP_LEN: begin
                                if (!rem_borrow &&
                                    remaining + 17'd1 < 17'(packet_byte) + 17'(OPT_HEAD_BYTES)) begin
                                    error_seen_next = 1'b1;
                                    phase_next      = PH_ERROR;
                                end else begin
                                    option_left_next = packet_byte;
                                    opt_phase_next   = (packet_byte != 8'd0) ? OP_DATA : OP_TYPE;
                                end
                            end
                            default: begin
                                option_left_next = option_left_reg - 8'd1;
                                if (option_left_reg == 8'd1) begin
                                    opt_phase_next = OP_TYPE;
                                end
                                if (option_zeroing_reg) begin
                                    out_byte = 8'd0;
                                end
                            end
                        endcase
                    end
                end
                PH_ROUTE: begin
                    if (rel == REL_NEXT_HDR) begin
                        next_type_next = packet_byte;
                    end else if (rel == REL_HDR_LEN) begin
                        end_sum         = {1'b0, header_start_next} + 17'(opt_hdr_len);
                        header_end_next = end_sum[16] ? 16'hFFFF : end_sum[15:0];
                    end else if (rel == REL_SEG_LEFT) begin
                        out_byte = 8'd0;
                    end
                end
                PH_AUTH: begin
                    if (rel == REL_NEXT_HDR) begin
                        next_type_next = packet_byte;
                    end else if (rel == REL_HDR_LEN) begin
                        end_sum         = {1'b0, header_start_next} + 17'(auth_hdr_len);
                        header_end_next = end_sum[16] ? 16'hFFFF : end_sum[15:0];
                    end else if (rel >= REL_AUTH_DATA && zero_auth_data) begin
                        out_byte = 8'd0;
                    end
                end
                default: begin
                end
            endcase

            byte_count_next = byte_count_reg + 16'd1;
        end
    end

    // Summary reported with the final word of a packet.
    always_comb begin
        if (error_seen_next) begin
            summary_nh = 8'd0;
        end else if (phase_next == PH_AUTH || phase_next == PH_DEST_AFTER_AUTH) begin
            summary_nh = TYPE_AUTH;
        end else begin
            summary_nh = next_type_next;
        end
        result.out_byte           = out_byte;
        result.last_out           = last_byte;
        result.status             = last_byte & error_seen_next;
        result.next_header        = last_byte ? summary_nh : 8'd0;
        result.prev_header_offset = last_byte ? last_nh_offset_next : 16'd0;
    end

    // Parse state; the final word of a packet returns it to the start state.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            phase_reg          <= PH_FIXED;
            opt_phase_reg      <= OP_TYPE;
            byte_count_reg     <= '0;
            next_type_reg      <= '0;
            header_start_reg   <= '0;
            header_end_reg     <= FIXED_HDR_BYTES;
            last_nh_offset_reg <= FIXED_NH_OFFSET;
            option_left_reg    <= '0;
            option_zeroing_reg <= 1'b0;
            error_seen_reg     <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            opt_phase_reg      <= opt_phase_next;
            byte_count_reg     <= byte_count_next;
            next_type_reg      <= next_type_next;
            header_start_reg   <= header_start_next;
            header_end_reg     <= header_end_next;
            last_nh_offset_reg <= last_nh_offset_next;
            option_left_reg    <= option_left_next;
            option_zeroing_reg <= option_zeroing_next;
            error_seen_reg     <= error_seen_next;
        end
    end

endmodule

// ===== hdl/ipv6ah_checker.sv =====
// Port-level checks for the IPv6 AH mutable-field clear unit, with its bind.
// Depends on the top level's port list only.
module ipv6ah_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_last_out,
    input logic        m_status,
    input logic [7:0]  m_next_header,
    input logic [15:0] m_prev_header_offset
);

    // A stalled result word holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_out))
        else $error("result word changed while stalled");

    // Summary fields are zero except on the final word of a packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_out |-> !m_status && m_next_header == 8'd0 &&
        m_prev_header_offset == 16'd0)
        else $error("summary fields set on a word that is not the final one");

    // An option overrun always reports a stopping header of zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_out && m_status |-> m_next_header == 8'd0)
        else $error("overrun reported with a nonzero next header");

    // The reported offset is the fixed header's field or lies past the fixed header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_out |-> m_prev_header_offset == 16'd6 ||
        m_prev_header_offset >= 16'd40)
        else $error("next-header offset inside the fixed header");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

endmodule

bind ipv6_ah_mutable_field_clear_unit ipv6ah_checker u_checker (.*);
